[rtl/txs_pkg.sv]
// ----------------------------------------------------------------------------
// txs_pkg
// Shared types, register indexes, codes and defaults of the texture sampler.
// ----------------------------------------------------------------------------
package txs_pkg;

  localparam int COORD_W         = 24;
  localparam int CFG_IDX_W       = 3;
  localparam int DEF_MAX_WIDTH   = 256;
  localparam int DEF_MAX_HEIGHT  = 256;
  localparam int DEF_FRAC_BITS   = 8;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_SAMPLE  = 1'b1;
  localparam logic FILTER_POINT = 1'b0;

  localparam logic [1:0] ADDR_WRAP   = 2'd0;
  localparam logic [1:0] ADDR_CLAMP  = 2'd1;
  localparam logic [1:0] ADDR_MIRROR = 2'd2;
  localparam logic [1:0] ADDR_BORDER = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_FILTER_MODE    = 3'd2,
    REG_ADDRESS_MODE_X = 3'd3,
    REG_ADDRESS_MODE_Y = 3'd4,
    REG_BORDER_COLOR   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic               func;
    logic [7:0]         pixel_x;
    logic [7:0]         pixel_y;
    logic [31:0]        pixel_value;
    logic signed [23:0] coord_u;
    logic signed [23:0] coord_v;
  } req_word_t;

  typedef struct packed {
    logic [15:0] out_alpha;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
  } rsp_word_t;

  typedef struct packed {
    logic [8:0]  image_width;
    logic [8:0]  image_height;
    logic        filter_mode;
    logic [1:0]  address_mode_x;
    logic [1:0]  address_mode_y;
    logic [31:0] border_color;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_WAIT,
    B_ROW,
    B_COL,
    B_OUT
  } back_state_t;

  // Width of one queue entry between the front and the back part.
  function automatic int entry_w(input int mw, input int mh, input int f);
    return 54 + 2 * $clog2(mw) + 2 * $clog2(mh) + 2 * f;
  endfunction

endpackage

[rtl/txs_ram.sv]
// ----------------------------------------------------------------------------
// txs_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module txs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/txs_fifo.sv]
// ----------------------------------------------------------------------------
// txs_fifo
// Short register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module txs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTRW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  count;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + PTRW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + PTRW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

[rtl/txs_front.sv]
// ----------------------------------------------------------------------------
// txs_front
// Accepts request words, resolves sample coordinates into texel positions
// with a bit-serial floored remainder per axis, and queues the work.
// ----------------------------------------------------------------------------
module txs_front import txs_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int ENTRY_W    = entry_w(DEF_MAX_WIDTH, DEF_MAX_HEIGHT, DEF_FRAC_BITS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_word_t          req_data,
  input  cfg_regs_t          cfg,
  output logic               q_push,
  output logic [ENTRY_W-1:0] q_wdata,
  input  logic               q_full
);

  localparam int IW   = COORD_W - FRAC_BITS;
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int NXW  = $clog2(2 * MAX_WIDTH + 1);
  localparam int NYW  = $clog2(2 * MAX_HEIGHT + 1);
  localparam int NW   = (NXW > NYW) ? NXW : NYW;
  localparam int PW   = (XW > YW) ? XW : YW;
  localparam int SW   = ((IW > NW) ? IW : NW) + 2;
  localparam int CNTW = $clog2(IW + 1);

  typedef struct packed {
    logic                 is_wr;
    logic [7:0]           wr_x;
    logic [7:0]           wr_y;
    logic [31:0]          wr_val;
    logic                 point;
    logic [XW-1:0]        px0;
    logic [XW-1:0]        px1;
    logic [YW-1:0]        py0;
    logic [YW-1:0]        py1;
    logic                 inx0;
    logic                 inx1;
    logic                 iny0;
    logic                 iny1;
    logic [FRAC_BITS-1:0] fu;
    logic [FRAC_BITS-1:0] fv;
  } entry_t;

  typedef struct packed {
    logic [PW-1:0] p0;
    logic [PW-1:0] p1;
    logic          in0;
    logic          in1;
  } axis_t;

  front_state_t          state;
  front_state_t          state_next;
  logic [CNTW-1:0]       cnt;
  req_word_t             item;
  logic signed [IW-1:0]  ci       [2];
  logic signed [IW-1:0]  cin      [2];
  logic [IW-1:0]         acc      [2];
  logic [NW-1:0]         rem      [2];
  logic [NW-1:0]         rem_step [2];
  logic [NW-1:0]         rres     [2];
  logic [NW-1:0]         nsz      [2];
  logic [NW-1:0]         modn     [2];
  logic [NW:0]           trial    [2];
  axis_t                 ax;
  axis_t                 ay;
  entry_t                ent;

  // Per-axis address resolution. For wrap and mirror, r is the floored
  // remainder of the coordinate by n (wrap) or 2n (mirror).
  function automatic axis_t resolve(input logic signed [IW-1:0] c,
                                    input logic [NW-1:0] r,
                                    input logic [NW-1:0] n,
                                    input logic [1:0] mode);
    axis_t                a;
    logic signed [SW-1:0] s0;
    logic signed [SW-1:0] s1;
    logic signed [SW-1:0] sn;
    logic [NW-1:0]        rp;
    logic [NW-1:0]        n2;
    logic [NW-1:0]        m1;
    s0    = SW'(c);
    s1    = s0 + SW'(1);
    sn    = signed'(SW'(n));
    rp    = r + NW'(1);
    n2    = n << 1;
    m1    = (rp == n2) ? '0 : rp;
    a.in0 = 1'b1;
    a.in1 = 1'b1;
    case (mode)
      ADDR_WRAP: begin
        a.p0 = PW'(r);
        a.p1 = (rp == n) ? '0 : PW'(rp);
      end
      ADDR_CLAMP: begin
        a.p0 = (s0 < 0) ? '0 : ((s0 >= sn) ? PW'(n - NW'(1)) : PW'(s0));
        a.p1 = (s1 < 0) ? '0 : ((s1 >= sn) ? PW'(n - NW'(1)) : PW'(s1));
      end
      ADDR_MIRROR: begin
        a.p0 = (r < n) ? PW'(r) : PW'(n2 - NW'(1) - r);
        a.p1 = (m1 < n) ? PW'(m1) : PW'(n2 - NW'(1) - m1);
      end
      default: begin
        a.in0 = (s0 >= 0) && (s0 < sn);
        a.in1 = (s1 >= 0) && (s1 < sn);
        a.p0  = PW'(s0);
        a.p1  = PW'(s1);
      end
    endcase
    return a;
  endfunction

  // Effective sizes and remainder moduli.
  always_comb begin
    nsz[0] = (cfg.image_width == '0) ? NW'(1) :
             ((int'(cfg.image_width) > MAX_WIDTH) ? NW'(MAX_WIDTH) : NW'(cfg.image_width));
    nsz[1] = (cfg.image_height == '0) ? NW'(1) :
             ((int'(cfg.image_height) > MAX_HEIGHT) ? NW'(MAX_HEIGHT) :
              NW'(cfg.image_height));
    modn[0] = (cfg.address_mode_x == ADDR_MIRROR) ? (nsz[0] << 1) : nsz[0];
    modn[1] = (cfg.address_mode_y == ADDR_MIRROR) ? (nsz[1] << 1) : nsz[1];
    cin[0]  = req_data.coord_u[COORD_W-1:FRAC_BITS];
    cin[1]  = req_data.coord_v[COORD_W-1:FRAC_BITS];
  end

  // One restoring remainder step per axis. A negative coordinate c is
  // reduced as ~c and reflected afterwards, which gives the floored result.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem[l], acc[l][IW-1]};
      if (trial[l] >= {1'b0, modn[l]}) begin
        rem_step[l] = NW'(trial[l] - {1'b0, modn[l]});
      end else begin
        rem_step[l] = trial[l][NW-1:0];
      end
      rres[l] = ci[l][IW-1] ? (modn[l] - NW'(1) - rem[l]) : rem[l];
    end
  end

  always_comb begin
    ax          = resolve(ci[0], rres[0], nsz[0], cfg.address_mode_x);
    ay          = resolve(ci[1], rres[1], nsz[1], cfg.address_mode_y);
    ent.is_wr   = (item.func == FUNC_WRITE);
    ent.wr_x    = item.pixel_x;
    ent.wr_y    = item.pixel_y;
    ent.wr_val  = item.pixel_value;
    ent.point   = (cfg.filter_mode == FILTER_POINT);
    ent.px0     = XW'(ax.p0);
    ent.px1     = XW'(ax.p1);
    ent.py0     = YW'(ay.p0);
    ent.py1     = YW'(ay.p1);
    ent.inx0    = ax.in0;
    ent.inx1    = ax.in1;
    ent.iny0    = ay.in0;
    ent.iny1    = ay.in1;
    ent.fu      = ent.point ? '0 : item.coord_u[FRAC_BITS-1:0];
    ent.fv      = ent.point ? '0 : item.coord_v[FRAC_BITS-1:0];
    q_wdata     = ent;
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (req_valid) begin
          state_next = (req_data.func == FUNC_SAMPLE) ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        if (cnt == CNTW'(IW - 1)) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == F_IDLE);
    q_push    = (state == F_PUSH) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == F_DIV) begin
        cnt <= cnt + CNTW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && req_valid) begin
      item <= req_data;
      for (int l = 0; l < 2; l++) begin
        ci[l]  <= cin[l];
        acc[l] <= cin[l][IW-1] ? ~cin[l] : cin[l];
        rem[l] <= '0;
      end
    end else if (state == F_DIV) begin
      for (int l = 0; l < 2; l++) begin
        acc[l] <= acc[l] << 1;
        rem[l] <= rem_step[l];
      end
    end
  end

endmodule

[rtl/txs_back.sv]
// ----------------------------------------------------------------------------
// txs_back
// Executes queued work: texel writes, up to four texel reads per sample,
// and the per-channel bilinear blend into the output register.
// ----------------------------------------------------------------------------
module txs_back import txs_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int ENTRY_W    = entry_w(DEF_MAX_WIDTH, DEF_MAX_HEIGHT, DEF_FRAC_BITS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  logic [ENTRY_W-1:0] q_rdata,
  output logic               q_pop,
  input  logic [31:0]        border_color,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_word_t          rsp_data
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = $clog2(DEPTH);
  localparam int RW   = FRAC_BITS + 10;
  localparam int SUMW = 2 * FRAC_BITS + 12;

  typedef struct packed {
    logic                 is_wr;
    logic [7:0]           wr_x;
    logic [7:0]           wr_y;
    logic [31:0]          wr_val;
    logic                 point;
    logic [XW-1:0]        px0;
    logic [XW-1:0]        px1;
    logic [YW-1:0]        py0;
    logic [YW-1:0]        py1;
    logic                 inx0;
    logic                 inx1;
    logic                 iny0;
    logic                 iny1;
    logic [FRAC_BITS-1:0] fu;
    logic [FRAC_BITS-1:0] fv;
  } entry_t;

  back_state_t            state;
  back_state_t            state_next;
  entry_t                 qe;
  entry_t                 cur;
  logic [1:0]             idx;
  logic [1:0]             last_idx;
  logic [1:0]             k;
  logic                   cap_v;
  logic [1:0]             cap_idx;
  logic                   cap_bord;
  logic [31:0]            tex [4];
  logic [31:0]            cap_val;
  logic [15:0]            res [4];
  logic signed [RW-1:0]   r0;
  logic signed [RW-1:0]   r1;
  logic signed [RW-1:0]   r0_next;
  logic signed [RW-1:0]   r1_next;
  logic signed [SUMW-1:0] sum;
  logic signed [SUMW-1:0] pc;
  logic signed [RW:0]     dr;
  logic signed [8:0]      dab;
  logic signed [8:0]      dcd;
  logic signed [RW-1:0]   pa;
  logic signed [RW-1:0]   pb;
  logic signed [FRAC_BITS:0] sfu;
  logic signed [FRAC_BITS:0] sfv;
  logic [7:0]             ca;
  logic [7:0]             cb;
  logic [7:0]             cc;
  logic [7:0]             cd;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic [31:0]            rdata;
  logic [XW-1:0]          rx;
  logic [YW-1:0]          ry;
  logic                   rin;
  logic                   load;

  function automatic logic [7:0] chan(input logic [31:0] t, input logic [1:0] sel);
    logic [7:0] c;
    case (sel)
      2'd0:    c = t[31:24];
      2'd1:    c = t[23:16];
      2'd2:    c = t[15:8];
      default: c = t[7:0];
    endcase
    return c;
  endfunction

  assign qe = entry_t'(q_rdata);

  txs_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (qe.wr_val),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Neighbor order: bit 0 of idx picks x+1, bit 1 picks y+1.
  always_comb begin
    rx       = idx[0] ? cur.px1 : cur.px0;
    ry       = idx[1] ? cur.py1 : cur.py0;
    rin      = (idx[0] ? cur.inx1 : cur.inx0) && (idx[1] ? cur.iny1 : cur.iny0);
    raddr    = AW'(ry) * AW'(MAX_WIDTH) + AW'(rx);
    waddr    = AW'(qe.wr_y) * AW'(MAX_WIDTH) + AW'(qe.wr_x);
    last_idx = cur.point ? 2'd0 : 2'd3;
    cap_val  = cap_bord ? border_color : rdata;
  end

  // Blend as A*S + (B-A)*f, first along u, then along v.
  always_comb begin
    ca      = chan(tex[0], k);
    cb      = chan(tex[1], k);
    cc      = chan(tex[2], k);
    cd      = chan(tex[3], k);
    sfu     = signed'({1'b0, cur.fu});
    sfv     = signed'({1'b0, cur.fv});
    dab     = signed'({1'b0, cb}) - signed'({1'b0, ca});
    dcd     = signed'({1'b0, cd}) - signed'({1'b0, cc});
    pa      = dab * sfu;
    pb      = dcd * sfu;
    r0_next = (RW'(signed'({1'b0, ca})) <<< FRAC_BITS) + pa;
    r1_next = (RW'(signed'({1'b0, cc})) <<< FRAC_BITS) + pb;
    dr      = {r1[RW-1], r1} - {r0[RW-1], r0};
    pc      = dr * sfv;
    sum     = (SUMW'(r0) <<< FRAC_BITS) + pc;
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty && !qe.is_wr) begin
          state_next = B_READ;
        end
      end
      B_READ: begin
        if (idx == last_idx) begin
          state_next = B_WAIT;
        end
      end
      B_WAIT: state_next = B_ROW;
      B_ROW:  state_next = B_COL;
      B_COL: begin
        if (k == 2'd3) begin
          state_next = B_OUT;
        end else begin
          state_next = B_ROW;
        end
      end
      B_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == B_IDLE) && !q_empty;
    we    = q_pop && qe.is_wr && (int'(qe.wr_x) < MAX_WIDTH) && (int'(qe.wr_y) < MAX_HEIGHT);
    load  = (state == B_OUT) && (!rsp_valid || rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cap_v     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cap_v <= (state == B_READ);
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= qe;
    end
    if (state == B_IDLE) begin
      idx <= '0;
    end else if (state == B_READ) begin
      idx <= idx + 2'd1;
    end
    if (state == B_WAIT) begin
      k <= '0;
    end else if (state == B_COL) begin
      k <= k + 2'd1;
    end
    cap_idx  <= idx;
    cap_bord <= !rin;
    if (cap_v) begin
      if (cur.point) begin
        for (int i = 0; i < 4; i++) begin
          tex[i] <= cap_val;
        end
      end else begin
        tex[cap_idx] <= cap_val;
      end
    end
    if (state == B_ROW) begin
      r0 <= r0_next;
      r1 <= r1_next;
    end
    if (state == B_COL) begin
      res[k] <= sum[2*FRAC_BITS-8 +: 16];
    end
    if (load) begin
      rsp_data.out_alpha <= res[0];
      rsp_data.out_red   <= res[1];
      rsp_data.out_green <= res[2];
      rsp_data.out_blue  <= res[3];
    end
  end

endmodule

[rtl/texture_sampler_bilinear_core.sv]
// ----------------------------------------------------------------------------
// texture_sampler_bilinear_core
// Bilinear texture sampler with per-axis wrap, clamp, mirror and border modes.
// ----------------------------------------------------------------------------
// Usage. A request word on req_* either writes one ARGB texel (func write) or
// samples the texture at a signed fixed-point coordinate (func sample). Each
// sample yields one response word on rsp_* with four 8.8 channels; writes
// yield nothing. Words are moved at edges where valid and ready are high.
// Configuration registers are written on cfg_* (always ready); the user must
// write them only while the block is idle, as the block does not enforce it.
// Timing. The front part resolves both axes with a bit-serial floored
// remainder, one bit per cycle over the integer part of the coordinate, and
// takes no new word until it has pushed the last one into the queue. The
// back part owns the texel memory: a bilinear sample makes four reads, a
// point sample one, then each channel takes a row and a column blend step.
// Reset clears the control state and loads the register defaults; texel
// memory is not cleared, so every texel must be written before it is read.
// When the receiver stalls, the response is held in its output register;
// the back part stops at its final step and the queue and front keep
// taking words until the queue fills.
// ----------------------------------------------------------------------------
module texture_sampler_bilinear_core import txs_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_word_t            req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_word_t            rsp_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int ENTRY_W = entry_w(MAX_WIDTH, MAX_HEIGHT, FRAC_BITS);

  cfg_regs_t          cfg;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;

  // Register writes never stall. Indexes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width    <= 9'd256;
      cfg.image_height   <= 9'd256;
      cfg.filter_mode    <= 1'b1;
      cfg.address_mode_x <= ADDR_WRAP;
      cfg.address_mode_y <= ADDR_WRAP;
      cfg.border_color   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    cfg.image_width    <= cfg_data[8:0];
        REG_IMAGE_HEIGHT:   cfg.image_height   <= cfg_data[8:0];
        REG_FILTER_MODE:    cfg.filter_mode    <= cfg_data[0];
        REG_ADDRESS_MODE_X: cfg.address_mode_x <= cfg_data[1:0];
        REG_ADDRESS_MODE_Y: cfg.address_mode_y <= cfg_data[1:0];
        REG_BORDER_COLOR:   cfg.border_color   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front part: accepts words and turns samples into resolved texel
  // positions, border flags and blend weights.
  txs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .cfg       (cfg),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .q_full    (q_full)
  );

  // Work queue between the two parts.
  txs_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back part: texel memory, fetches and the blend datapath.
  txs_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .border_color (cfg.border_color),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp_data     (rsp_data)
  );

`ifndef SYNTHESIS
  // The front part must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("work queue written while full");

  // The back part must never take an entry from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("work queue read while empty");

  // A queue that was empty and was not pushed stays empty.
  a_empty_holds: assert property (@(posedge clk) disable iff (rst)
    (q_empty && !q_push) |=> q_empty)
    else $error("work queue filled without a push");
`endif

endmodule

[verif/tb_texture_sampler_bilinear_core.sv]
// ----------------------------------------------------------------------------
// tb_texture_sampler_bilinear_core
// Self-checking bench: texel writes and point/bilinear samples are driven with
// random gaps; a behavioral sampler predicts every response word, and the
// monitor compares each one channel by channel against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_texture_sampler_bilinear_core;
  import txs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_W = 256;
  localparam int MEM_H = 256;
  localparam int FILL_SPAN = 16;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_word_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_word_t rsp_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  texture_sampler_bilinear_core u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the sampler's state. Texels that were never written are
  // tracked so that samples are only aimed where every fetch hits real data.
  logic [31:0] texels [MEM_W*MEM_H];
  bit          written [MEM_W*MEM_H];
  cfg_regs_t   shadow_cfg;

  req_word_t pending_words [$];
  rsp_word_t expected_colors [$];
  int        req_gap = 0;
  int        rsp_gap = 0;
  int        error_count = 0;
  longint    cycle_count = 0;

  // Resolve one axis by address mode; returns 0 when the fetch is on the border.
  function automatic bit map_axis(input int c, input int n, input logic [1:0] mode,
                                  output int pos);
    int m;
    pos = 0;
    case (mode)
      ADDR_WRAP: begin
        m = c % n;
        if (m < 0) m += n;
        pos = m;
      end
      ADDR_CLAMP: begin
        pos = (c < 0) ? 0 : ((c >= n) ? n - 1 : c);
      end
      ADDR_MIRROR: begin
        m = c % (2 * n);
        if (m < 0) m += 2 * n;
        pos = (m < n) ? m : 2 * n - 1 - m;
      end
      default: begin
        if (c < 0 || c >= n) return 1'b0;
        pos = c;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic int clip_size(input logic [8:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // Returns the memory address of a fetch, or -1 for a border fetch.
  function automatic int texel_addr(input int x, input int y);
    int px, py;
    bit inx, iny;
    inx = map_axis(x, clip_size(shadow_cfg.image_width, MEM_W), shadow_cfg.address_mode_x, px);
    iny = map_axis(y, clip_size(shadow_cfg.image_height, MEM_H), shadow_cfg.address_mode_y, py);
    if (!inx || !iny) return -1;
    return py * MEM_W + px;
  endfunction

  function automatic logic [31:0] fetch_texel(input int x, input int y);
    int a;
    a = texel_addr(x, y);
    return (a < 0) ? shadow_cfg.border_color : texels[a];
  endfunction

  // True when every texel the sample would read has been written.
  function automatic bit sample_is_safe(input req_word_t w);
    int x, y, a;
    x = int'(w.coord_u) >>> DEF_FRAC_BITS;
    y = int'(w.coord_v) >>> DEF_FRAC_BITS;
    for (int dy = 0; dy < 2; dy++)
      for (int dx = 0; dx < 2; dx++) begin
        if ((dx | dy) && shadow_cfg.filter_mode == FILTER_POINT) continue;
        a = texel_addr(x + dx, y + dy);
        if (a >= 0 && !written[a]) return 1'b0;
      end
    return 1'b1;
  endfunction

  // Applies one request word to the shadow state and queues any response.
  task automatic predict_sampler(input req_word_t w);
    int x, y;
    logic [31:0] fu, fv, sc;
    logic [31:0] ta, tb, tc, td;
    logic [63:0] r0, r1, acc;
    logic [7:0] ca, cb, cc, cd;
    logic [15:0] chan [4];
    rsp_word_t r;
    if (w.func == FUNC_WRITE) begin
      texels[int'(w.pixel_y) * MEM_W + int'(w.pixel_x)] = w.pixel_value;
      written[int'(w.pixel_y) * MEM_W + int'(w.pixel_x)] = 1'b1;
      return;
    end
    // Floor division of the signed coordinate; the fraction is its low bits.
    x  = int'(w.coord_u) >>> DEF_FRAC_BITS;
    y  = int'(w.coord_v) >>> DEF_FRAC_BITS;
    fu = {24'd0, w.coord_u[7:0]};
    fv = {24'd0, w.coord_v[7:0]};
    sc = 32'd1 << DEF_FRAC_BITS;
    ta = fetch_texel(x, y);
    tb = fetch_texel(x + 1, y);
    tc = fetch_texel(x, y + 1);
    td = fetch_texel(x + 1, y + 1);
    for (int k = 0; k < 4; k++) begin
      ca = ta[31-8*k -: 8];
      cb = tb[31-8*k -: 8];
      cc = tc[31-8*k -: 8];
      cd = td[31-8*k -: 8];
      if (shadow_cfg.filter_mode == FILTER_POINT) begin
        chan[k] = {ca, 8'd0};
      end else begin
        r0 = 64'(ca) * (sc - fu) + 64'(cb) * fu;
        r1 = 64'(cc) * (sc - fu) + 64'(cd) * fu;
        acc = r0 * (sc - fv) + r1 * fv;
        chan[k] = 16'(acc >> (2 * DEF_FRAC_BITS - 8));
      end
    end
    r.out_alpha = chan[0];
    r.out_red   = chan[1];
    r.out_green = chan[2];
    r.out_blue  = chan[3];
    expected_colors.push_back(r);
  endtask

  // Driver: presents queued words one at a time with a random gap before each.
  // The prediction is made at acceptance so that it sees the state in order.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      predict_sampler(req_data);
      if (pending_words.size() > 0 && $urandom_range(0, 3) == 0) begin
        // Back-to-back word: valid stays high, only the payload moves on.
        req_data <= pending_words.pop_front();
        req_gap = 0;
      end else begin
        req_valid <= 1'b0;
        req_gap = $urandom_range(0, 18);
      end
    end else if (!req_valid && pending_words.size() > 0) begin
      if (req_gap > 0) begin
        req_gap--;
      end else begin
        req_data <= pending_words.pop_front();
        req_valid <= 1'b1;
      end
    end
  end

  // Monitor: checks each accepted response word and draws the next stall.
  always @(posedge clk) begin
    rsp_word_t exp_w;
    cycle_count++;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_colors.size() == 0) begin
          $error("response word with nothing expected: %h", rsp_data);
          error_count++;
        end else begin
          exp_w = expected_colors.pop_front();
          if (rsp_data.out_alpha !== exp_w.out_alpha) begin
            $error("out_alpha expected %h actual %h", exp_w.out_alpha, rsp_data.out_alpha);
            error_count++;
          end
          if (rsp_data.out_red !== exp_w.out_red) begin
            $error("out_red expected %h actual %h", exp_w.out_red, rsp_data.out_red);
            error_count++;
          end
          if (rsp_data.out_green !== exp_w.out_green) begin
            $error("out_green expected %h actual %h", exp_w.out_green, rsp_data.out_green);
            error_count++;
          end
          if (rsp_data.out_blue !== exp_w.out_blue) begin
            $error("out_blue expected %h actual %h", exp_w.out_blue, rsp_data.out_blue);
            error_count++;
          end
        end
        rsp_gap = $urandom_range(0, 18);
        if ($urandom_range(0, 4) == 0) rsp_gap = 0;
      end
      if (rsp_gap > 0) begin
        rsp_gap--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Writes one register on the configuration channel and mirrors it.
  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:    shadow_cfg.image_width    = value[8:0];
      REG_IMAGE_HEIGHT:   shadow_cfg.image_height   = value[8:0];
      REG_FILTER_MODE:    shadow_cfg.filter_mode    = value[0];
      REG_ADDRESS_MODE_X: shadow_cfg.address_mode_x = value[1:0];
      REG_ADDRESS_MODE_Y: shadow_cfg.address_mode_y = value[1:0];
      default:            shadow_cfg.border_color   = value;
    endcase
  endtask

  // Waits until the driver is empty and every response has come back, then
  // lets the pipeline drain so a trailing write has landed too.
  task automatic wait_idle();
    while (pending_words.size() > 0 || req_valid || expected_colors.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Queues a write and marks it in the safety map right away, so later
  // samples in the same batch may use it.
  task automatic queue_write(input int x, input int y, input logic [31:0] value);
    req_word_t w;
    w = '0;
    w.func = FUNC_WRITE;
    w.pixel_x = 8'(x);
    w.pixel_y = 8'(y);
    w.pixel_value = value;
    w.coord_u = 24'($urandom);
    w.coord_v = 24'($urandom);
    pending_words.push_back(w);
    written[(y % MEM_H) * MEM_W + (x % MEM_W)] = 1'b1;
  endtask

  // Queues a sample if every texel it reads is already in memory. Writes
  // ahead of it in the queue count, since they are marked when queued.
  task automatic queue_sample(input logic signed [23:0] u, input logic signed [23:0] v);
    req_word_t w;
    w.func = FUNC_SAMPLE;
    w.pixel_x = 8'($urandom);
    w.pixel_y = 8'($urandom);
    w.pixel_value = $urandom;
    w.coord_u = u;
    w.coord_v = v;
    if (sample_is_safe(w)) pending_words.push_back(w);
  endtask

  function automatic logic signed [23:0] rand_coord(input int span);
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'(int'($urandom_range(0, 2 * span * 256)) - span * 256);
      default: return 24'($urandom_range(0, span * 256 + 255));
    endcase
  endfunction

  initial begin
    int w_sz, h_sz, count;
    shadow_cfg = '0;
    shadow_cfg.image_width  = 9'd256;
    shadow_cfg.image_height = 9'd256;
    shadow_cfg.filter_mode  = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Fill the low corner of the memory and the parts of the last two rows and
    // columns that cross the low rows and columns or each other, which covers
    // every texel the samples below can reach; two corners hold the extreme values.
    for (int y = 0; y < MEM_H; y++)
      for (int x = 0; x < MEM_W; x++)
        if ((x < FILL_SPAN || x >= MEM_W - 2) && (y < FILL_SPAN || y >= MEM_H - 2))
          queue_write(x, y, (x == 0 && y == 0) ? 32'hFFFF_FFFF :
                            (x == 255 && y == 255) ? 32'h0 : $urandom);
    wait_idle();

    // Directed part at reset settings: extreme coordinates, zero and full
    // fractions, negative wrap.
    queue_sample(24'sh000000, 24'sh000000);
    queue_sample(24'sh7FFFFF, 24'sh7FFFFF);
    queue_sample(24'sh800000, 24'sh800000);
    queue_sample(24'sh0000FF, 24'sh0000FF);
    queue_sample(24'shFFFF80, 24'shFFFF01);
    queue_sample(24'sh00FF80, 24'sh00FF40);
    queue_write(255, 255, 32'hFFFF_FFFF);
    queue_sample(24'sh00FFFF, 24'sh00FFFF);
    wait_idle();

    // Point sampling with each address mode on small images, out-of-range sizes of
    // zero and above maximum, then bilinear samples; border color at both extremes.
    write_reg(REG_FILTER_MODE, 32'(FILTER_POINT));
    write_reg(REG_BORDER_COLOR, 32'hFFFF_FFFF);
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_ADDRESS_MODE_X, 32'(m));
      write_reg(REG_ADDRESS_MODE_Y, 32'(3 - m));
      write_reg(REG_IMAGE_WIDTH, (m == 0) ? 32'd0 : 32'd3);
      write_reg(REG_IMAGE_HEIGHT, (m == 1) ? 32'd511 : 32'd1);
      queue_sample(24'shFFFE00, 24'sh000300);
      queue_sample(24'sh000500, 24'shFFFF00);
      queue_sample(24'sh000280, 24'sh000080);
      wait_idle();
    end
    write_reg(REG_FILTER_MODE, 32'd1);
    write_reg(REG_BORDER_COLOR, 32'h0);
    queue_sample(24'shFFFF80, 24'sh000080);
    queue_sample(24'sh000380, 24'sh0000C0);
    wait_idle();

    // Random phases: each with its own settings; mostly small images so the
    // address modes fold often, the rest as large as the filled corner.
    // Writes keep refreshing texels in the middle of the sampling.
    count = 0;
    for (int phase = 0; count < 660; phase++) begin
      w_sz = ($urandom_range(0, 4) == 0) ? FILL_SPAN : $urandom_range(1, 8);
      h_sz = ($urandom_range(0, 4) == 0) ? FILL_SPAN : $urandom_range(1, 8);
      write_reg(REG_IMAGE_WIDTH, 32'(w_sz));
      write_reg(REG_IMAGE_HEIGHT, 32'(h_sz));
      write_reg(REG_FILTER_MODE, 32'($urandom_range(0, 3) != 0));
      write_reg(REG_ADDRESS_MODE_X, 32'($urandom_range(0, 3)));
      write_reg(REG_ADDRESS_MODE_Y, 32'($urandom_range(0, 3)));
      write_reg(REG_BORDER_COLOR, $urandom);
      for (int i = 0; i < 80; i++) begin
        if ($urandom_range(0, 4) == 0)
          queue_write($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
        else
          queue_sample(rand_coord(2 * (w_sz > 16 ? 128 : w_sz)),
                       rand_coord(2 * (h_sz > 16 ? 128 : h_sz)));
        count++;
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/txs_pkg.sv
rtl/txs_ram.sv
rtl/txs_fifo.sv
rtl/txs_front.sv
rtl/txs_back.sv
rtl/texture_sampler_bilinear_core.sv
verif/tb_texture_sampler_bilinear_core.sv
